### rtl/shpd_pkg.sv
// Shared types, constants and the fixed prefix-code table of the packet decoder.
package shpd_pkg;

  localparam logic [7:0] HDR_RAW      = 8'd255;
  localparam logic [7:0] HDR_PAD_MAX  = 8'd7;
  localparam int unsigned CODE_LEN_MAX = 10;
  localparam int unsigned CODE_LEN_MIN = 3;
  localparam int unsigned NUM_CODES    = 256;

  localparam logic [1:0] KIND_SYM = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  typedef struct packed {
    logic accept;    // take the byte on the input channel
    logic dec_step;  // one table lookup on the bit window
    logic raw_end;   // emit the end word after the last raw byte
  } cmd_t;

  typedef struct packed {
    logic can_act;    // the pending slot can take a new word this cycle
    logic to_decode;  // the byte on the input starts a decode run
    logic to_rawend;  // the byte on the input needs a trailing end word
    logic dec_done;   // this lookup finishes the current byte
  } stat_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] len;
    logic [7:0] sym;
  } lookup_t;

  // Each entry: code length, code bits with the first bit received as MSB, symbol.
  localparam logic [21:0] CODE_TAB [NUM_CODES] = '{
    {4'd4,10'b0000,8'd128},{4'd8,10'b00010000,8'd38},{4'd8,10'b00010001,8'd34},
    {4'd9,10'b000100100,8'd80},{4'd10,10'b0001001010,8'd110},
    {4'd10,10'b0001001011,8'd144},{4'd8,10'b00010011,8'd67},
    {4'd9,10'b000101000,8'd74},{4'd10,10'b0001010010,8'd243},
    {4'd10,10'b0001010011,8'd142},{4'd8,10'b00010101,8'd37},
    {4'd9,10'b000101100,8'd124},{4'd9,10'b000101101,8'd58},
    {4'd8,10'b00010111,8'd182},{4'd8,10'b00011000,8'd36},
    {4'd10,10'b0001100100,8'd221},{4'd10,10'b0001100101,8'd131},
    {4'd10,10'b0001100110,8'd245},{4'd10,10'b0001100111,8'd163},
    {4'd8,10'b00011010,8'd35},{4'd9,10'b000110110,8'd113},
    {4'd9,10'b000110111,8'd85},{4'd8,10'b00011100,8'd41},
    {4'd9,10'b000111010,8'd77},{4'd10,10'b0001110110,8'd199},
    {4'd10,10'b0001110111,8'd130},{4'd9,10'b000111100,8'd206},
    {4'd10,10'b0001111010,8'd185},{4'd10,10'b0001111011,8'd153},
    {4'd9,10'b000111110,8'd70},{4'd9,10'b000111111,8'd118},
    {4'd5,10'b00100,8'd3},{4'd5,10'b00101,8'd5},{4'd7,10'b0011000,8'd24},
    {4'd10,10'b0011001000,8'd198},{4'd10,10'b0011001001,8'd190},
    {4'd9,10'b001100101,8'd63},{4'd10,10'b0011001100,8'd139},
    {4'd10,10'b0011001101,8'd186},{4'd9,10'b001100111,8'd75},
    {4'd8,10'b00110100,8'd44},{4'd10,10'b0011010100,8'd240},
    {4'd10,10'b0011010101,8'd218},{4'd9,10'b001101011,8'd56},
    {4'd8,10'b00110110,8'd40},{4'd8,10'b00110111,8'd39},
    {4'd10,10'b0011100000,8'd244},{4'd10,10'b0011100001,8'd247},
    {4'd9,10'b001110001,8'd81},{4'd8,10'b00111001,8'd65},
    {4'd9,10'b001110100,8'd9},{4'd9,10'b001110101,8'd125},
    {4'd9,10'b001110110,8'd68},{4'd9,10'b001110111,8'd60},
    {4'd9,10'b001111000,8'd25},{4'd10,10'b0011110010,8'd191},
    {4'd10,10'b0011110011,8'd138},{4'd9,10'b001111010,8'd86},
    {4'd9,10'b001111011,8'd17},{4'd9,10'b001111100,8'd23},
    {4'd10,10'b0011111010,8'd220},{4'd10,10'b0011111011,8'd178},
    {4'd10,10'b0011111100,8'd165},{4'd10,10'b0011111101,8'd194},
    {4'd9,10'b001111111,8'd14},{4'd3,10'b010,8'd0},
    {4'd9,10'b011000000,8'd208},{4'd10,10'b0110000010,8'd150},
    {4'd10,10'b0110000011,8'd157},{4'd8,10'b01100001,8'd181},
    {4'd8,10'b01100010,8'd222},{4'd10,10'b0110001100,8'd216},
    {4'd10,10'b0110001101,8'd230},{4'd9,10'b011000111,8'd211},
    {4'd10,10'b0110010000,8'd252},{4'd10,10'b0110010001,8'd141},
    {4'd9,10'b011001001,8'd10},{4'd8,10'b01100101,8'd42},
    {4'd10,10'b0110011000,8'd134},{4'd10,10'b0110011001,8'd135},
    {4'd9,10'b011001101,8'd104},{4'd9,10'b011001110,8'd103},
    {4'd10,10'b0110011110,8'd187},{4'd10,10'b0110011111,8'd225},
    {4'd5,10'b01101,8'd95},{4'd4,10'b0111,8'd32},{4'd8,10'b10000000,8'd57},
    {4'd9,10'b100000010,8'd61},{4'd10,10'b1000000110,8'd183},
    {4'd10,10'b1000000111,8'd237},{4'd10,10'b1000001000,8'd233},
    {4'd10,10'b1000001001,8'd234},{4'd10,10'b1000001010,8'd246},
    {4'd10,10'b1000001011,8'd203},{4'd10,10'b1000001100,8'd250},
    {4'd10,10'b1000001101,8'd147},{4'd9,10'b100000111,8'd79},
    {4'd7,10'b1000010,8'd129},{4'd9,10'b100001100,8'd7},
    {4'd10,10'b1000011010,8'd143},{4'd10,10'b1000011011,8'd136},
    {4'd9,10'b100001110,8'd20},{4'd10,10'b1000011110,8'd179},
    {4'd10,10'b1000011111,8'd148},{4'd9,10'b100010000,8'd28},
    {4'd9,10'b100010001,8'd106},{4'd9,10'b100010010,8'd101},
    {4'd9,10'b100010011,8'd87},{4'd8,10'b10001010,8'd66},
    {4'd10,10'b1000101100,8'd180},{4'd10,10'b1000101101,8'd219},
    {4'd10,10'b1000101110,8'd227},{4'd10,10'b1000101111,8'd241},
    {4'd8,10'b10001100,8'd26},{4'd9,10'b100011010,8'd251},
    {4'd10,10'b1000110110,8'd229},{4'd10,10'b1000110111,8'd214},
    {4'd8,10'b10001110,8'd54},{4'd8,10'b10001111,8'd69},
    {4'd10,10'b1001000000,8'd231},{4'd10,10'b1001000001,8'd212},
    {4'd10,10'b1001000010,8'd156},{4'd10,10'b1001000011,8'd176},
    {4'd9,10'b100100010,8'd93},{4'd9,10'b100100011,8'd83},
    {4'd9,10'b100100100,8'd96},{4'd9,10'b100100101,8'd253},
    {4'd9,10'b100100110,8'd30},{4'd9,10'b100100111,8'd13},
    {4'd10,10'b1001010000,8'd175},{4'd10,10'b1001010001,8'd254},
    {4'd9,10'b100101001,8'd94},{4'd9,10'b100101010,8'd159},
    {4'd9,10'b100101011,8'd27},{4'd9,10'b100101100,8'd8},
    {4'd10,10'b1001011010,8'd204},{4'd10,10'b1001011011,8'd226},
    {4'd8,10'b10010111,8'd78},{4'd9,10'b100110000,8'd107},
    {4'd9,10'b100110001,8'd88},{4'd9,10'b100110010,8'd31},
    {4'd10,10'b1001100110,8'd137},{4'd10,10'b1001100111,8'd169},
    {4'd10,10'b1001101000,8'd215},{4'd10,10'b1001101001,8'd145},
    {4'd9,10'b100110101,8'd6},{4'd8,10'b10011011,8'd4},
    {4'd7,10'b1001110,8'd127},{4'd9,10'b100111100,8'd99},
    {4'd10,10'b1001111010,8'd209},{4'd10,10'b1001111011,8'd217},
    {4'd10,10'b1001111100,8'd213},{4'd10,10'b1001111101,8'd238},
    {4'd10,10'b1001111110,8'd177},{4'd10,10'b1001111111,8'd170},
    {4'd4,10'b1010,8'd132},{4'd9,10'b101100000,8'd22},
    {4'd9,10'b101100001,8'd12},{4'd8,10'b10110001,8'd114},
    {4'd10,10'b1011001000,8'd158},{4'd10,10'b1011001001,8'd197},
    {4'd9,10'b101100101,8'd97},{4'd8,10'b10110011,8'd45},
    {4'd8,10'b10110100,8'd46},{4'd9,10'b101101010,8'd112},
    {4'd10,10'b1011010110,8'd174},{4'd10,10'b1011010111,8'd249},
    {4'd9,10'b101101100,8'd224},{4'd9,10'b101101101,8'd102},
    {4'd10,10'b1011011100,8'd171},{4'd10,10'b1011011101,8'd151},
    {4'd9,10'b101101111,8'd193},{4'd9,10'b101110000,8'd15},
    {4'd9,10'b101110001,8'd16},{4'd9,10'b101110010,8'd2},
    {4'd9,10'b101110011,8'd168},{4'd8,10'b10111010,8'd49},
    {4'd9,10'b101110110,8'd91},{4'd9,10'b101110111,8'd146},
    {4'd8,10'b10111100,8'd48},{4'd9,10'b101111010,8'd173},
    {4'd9,10'b101111011,8'd29},{4'd9,10'b101111100,8'd19},
    {4'd9,10'b101111101,8'd126},{4'd9,10'b101111110,8'd92},
    {4'd9,10'b101111111,8'd242},{4'd9,10'b110000000,8'd205},
    {4'd9,10'b110000001,8'd192},{4'd10,10'b1100000100,8'd235},
    {4'd10,10'b1100000101,8'd149},{4'd9,10'b110000011,8'd255},
    {4'd9,10'b110000100,8'd223},{4'd9,10'b110000101,8'd184},
    {4'd8,10'b11000011,8'd248},{4'd9,10'b110001000,8'd108},
    {4'd9,10'b110001001,8'd236},{4'd9,10'b110001010,8'd111},
    {4'd9,10'b110001011,8'd90},{4'd9,10'b110001100,8'd117},
    {4'd9,10'b110001101,8'd115},{4'd8,10'b11000111,8'd71},
    {4'd8,10'b11001000,8'd11},{4'd8,10'b11001001,8'd50},
    {4'd9,10'b110010100,8'd188},{4'd9,10'b110010101,8'd119},
    {4'd9,10'b110010110,8'd122},{4'd10,10'b1100101110,8'd167},
    {4'd10,10'b1100101111,8'd162},{4'd7,10'b1100110,8'd160},
    {4'd8,10'b11001110,8'd133},{4'd9,10'b110011110,8'd123},
    {4'd9,10'b110011111,8'd21},{4'd8,10'b11010000,8'd59},
    {4'd10,10'b1101000100,8'd155},{4'd10,10'b1101000101,8'd154},
    {4'd9,10'b110100011,8'd98},{4'd7,10'b1101001,8'd43},
    {4'd8,10'b11010100,8'd76},{4'd8,10'b11010101,8'd51},
    {4'd9,10'b110101100,8'd201},{4'd9,10'b110101101,8'd116},
    {4'd8,10'b11010111,8'd72},{4'd9,10'b110110000,8'd109},
    {4'd9,10'b110110001,8'd100},{4'd8,10'b11011001,8'd121},
    {4'd9,10'b110110100,8'd195},{4'd9,10'b110110101,8'd232},
    {4'd8,10'b11011011,8'd18},{4'd6,10'b110111,8'd1},
    {4'd7,10'b1110000,8'd164},{4'd9,10'b111000100,8'd120},
    {4'd9,10'b111000101,8'd189},{4'd8,10'b11100011,8'd73},
    {4'd8,10'b11100100,8'd196},{4'd9,10'b111001010,8'd239},
    {4'd9,10'b111001011,8'd210},{4'd8,10'b11100110,8'd64},
    {4'd8,10'b11100111,8'd62},{4'd5,10'b11101,8'd89},
    {4'd7,10'b1111000,8'd33},{4'd9,10'b111100100,8'd228},
    {4'd9,10'b111100101,8'd161},{4'd8,10'b11110011,8'd55},
    {4'd8,10'b11110100,8'd84},{4'd8,10'b11110101,8'd152},
    {4'd7,10'b1111011,8'd47},{4'd9,10'b111110000,8'd207},
    {4'd9,10'b111110001,8'd172},{4'd8,10'b11111001,8'd140},
    {4'd8,10'b11111010,8'd82},{4'd8,10'b11111011,8'd166},
    {4'd8,10'b11111100,8'd53},{4'd8,10'b11111101,8'd105},
    {4'd8,10'b11111110,8'd52},{4'd9,10'b111111110,8'd202},
    {4'd9,10'b111111111,8'd200}
  };

  // Matches the oldest bits (bit 0 first) against every code of at most lim bits.
  // The code is prefix free, so at most one entry hits.
  function automatic lookup_t code_lookup(input logic [9:0] bits, input logic [3:0] lim);
    logic [9:0] rev;
    logic [3:0] len;
    logic [9:0] code;
    lookup_t    res;
    res = '0;
    for (int i = 0; i < 10; i++) begin
      rev[9-i] = bits[i];
    end
    for (int e = 0; e < NUM_CODES; e++) begin
      len  = CODE_TAB[e][21:18];
      code = CODE_TAB[e][17:8];
      if ((len <= lim) && ((rev >> (4'd10 - len)) == code)) begin
        res.hit = 1'b1;
        res.len = res.len | len;
        res.sym = res.sym | CODE_TAB[e][7:0];
      end
    end
    return res;
  endfunction

endpackage

### rtl/shpd_ctrl.sv
// Sequencer of the packet decoder: takes bytes, steps the lookup loop and issues the end word of raw packets.
module shpd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  shpd_pkg::stat_t stat_i,
  output shpd_pkg::cmd_t  cmd_o
);
  import shpd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DECODE, ST_RAWEND} state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = stat_i.can_act;
        cmd_o.accept = in_valid_i && stat_i.can_act;
        if (cmd_o.accept) begin
          if (stat_i.to_decode) begin
            state_d = ST_DECODE;
          end else if (stat_i.to_rawend) begin
            state_d = ST_RAWEND;
          end
        end
      end
      ST_DECODE: begin
        cmd_o.dec_step = stat_i.can_act;
        if (stat_i.can_act && stat_i.dec_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_RAWEND: begin
        cmd_o.raw_end = stat_i.can_act;
        if (stat_i.can_act) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/shpd_datapath.sv
// Bit window, table lookup, pending word and output register of the packet decoder.
module shpd_datapath #(
  parameter int unsigned MAX_CODE_BITS = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  shpd_pkg::cmd_t  cmd_i,
  output shpd_pkg::stat_t stat_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_first_i,
  input  logic            in_last_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_sym_o,
  output logic [1:0]      out_kind_o,
  output logic            out_last_o
);
  import shpd_pkg::*;

  localparam int unsigned WIN_W  = MAX_CODE_BITS + 7;
  localparam int unsigned FILL_W = $clog2(WIN_W + 1);

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_RAW     = 2'd1;
  localparam logic [1:0] MODE_CODED   = 2'd2;
  localparam logic [1:0] MODE_DISCARD = 2'd3;

  logic [WIN_W-1:0]  win_q, win_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [1:0]        mode_q, mode_d;
  logic [2:0]        pad_q, pad_d;
  logic              last_q, last_d;

  logic       pend_v_q, pend_v_d, pend_last_q, pend_last_d;
  logic [7:0] pend_sym_q, pend_sym_d;
  logic [1:0] pend_kind_q, pend_kind_d;
  logic       out_v_q, out_v_d, out_last_q, out_last_d;
  logic [7:0] out_sym_q, out_sym_d;
  logic [1:0] out_kind_q, out_kind_d;

  logic       out_free, can, gen, gen_last, fin, push;
  logic [7:0] gen_sym;
  logic [1:0] gen_kind;
  logic [3:0] lim;
  lookup_t    lk;
  logic       enough, over_pad;

  assign out_free = !out_v_q || out_ready_i;
  assign can      = !pend_v_q || out_free;
  assign lim      = (fill_q >= FILL_W'(CODE_LEN_MAX)) ? 4'(CODE_LEN_MAX) : fill_q[3:0];
  assign lk       = code_lookup(win_q[9:0], lim);
  assign enough   = fill_q >= FILL_W'(CODE_LEN_MIN);
  assign over_pad = fill_q > FILL_W'(pad_q);

  assign stat_o.can_act   = can;
  assign stat_o.to_decode = !in_first_i && (mode_q == MODE_CODED);
  assign stat_o.to_rawend = !in_first_i && (mode_q == MODE_RAW) && in_last_i;
  assign stat_o.dec_done  = last_q ? !(over_pad && lk.hit) : !(enough && lk.hit);

  always_comb begin
    win_d    = win_q;
    fill_d   = fill_q;
    mode_d   = mode_q;
    pad_d    = pad_q;
    last_d   = last_q;
    gen      = 1'b0;
    gen_sym  = 8'd0;
    gen_kind = KIND_SYM;
    gen_last = 1'b1;
    fin      = 1'b0;

    if (cmd_i.accept) begin
      if (in_first_i) begin
        win_d  = '0;
        fill_d = '0;
        pad_d  = 3'd0;
        if (in_byte_i == HDR_RAW) begin
          mode_d = MODE_RAW;
          if (in_last_i) begin
            gen      = 1'b1;
            gen_kind = KIND_END;
            mode_d   = MODE_IDLE;
          end
        end else if (in_byte_i <= HDR_PAD_MAX) begin
          pad_d  = in_byte_i[2:0];
          mode_d = MODE_CODED;
          if (in_last_i) begin
            gen      = 1'b1;
            gen_kind = (in_byte_i[2:0] == 3'd0) ? KIND_END : KIND_ERR;
            mode_d   = MODE_IDLE;
          end
        end else begin
          gen      = 1'b1;
          gen_kind = KIND_ERR;
          mode_d   = in_last_i ? MODE_IDLE : MODE_DISCARD;
        end
      end else begin
        case (mode_q)
          MODE_DISCARD: begin
            if (in_last_i) begin
              mode_d = MODE_IDLE;
            end
          end
          MODE_RAW: begin
            gen      = 1'b1;
            gen_sym  = in_byte_i;
            gen_last = !in_last_i;
          end
          MODE_CODED: begin
            win_d  = win_q | (WIN_W'(in_byte_i) << fill_q);
            fill_d = fill_q + FILL_W'(8);
            last_d = in_last_i;
          end
          default: ;
        endcase
      end
    end

    if (cmd_i.raw_end) begin
      gen      = 1'b1;
      gen_kind = KIND_END;
      mode_d   = MODE_IDLE;
    end

    if (cmd_i.dec_step) begin
      if (!last_q) begin
        if (enough && lk.hit) begin
          gen      = 1'b1;
          gen_sym  = lk.sym;
          gen_last = 1'b0;
          win_d    = win_q >> lk.len;
          fill_d   = fill_q - FILL_W'(lk.len);
        end else if (fill_q >= FILL_W'(MAX_CODE_BITS)) begin
          gen      = 1'b1;
          gen_kind = KIND_ERR;
          mode_d   = MODE_DISCARD;
        end else begin
          fin = 1'b1;
        end
      end else begin
        if (over_pad && lk.hit) begin
          gen      = 1'b1;
          gen_sym  = lk.sym;
          gen_last = 1'b0;
          win_d    = win_q >> lk.len;
          fill_d   = fill_q - FILL_W'(lk.len);
        end else begin
          // Either the data ran out cleanly at the pad bits or a code is cut short.
          gen      = 1'b1;
          gen_kind = over_pad ? KIND_ERR : KIND_END;
          mode_d   = MODE_IDLE;
          win_d    = '0;
          fill_d   = '0;
        end
      end
    end
  end

  // The pending word moves on once it is known to be last or a newer word replaces it.
  assign push = pend_v_q && out_free && (pend_last_q || gen || fin);

  always_comb begin
    pend_v_d    = pend_v_q;
    pend_last_d = pend_last_q;
    pend_sym_d  = pend_sym_q;
    pend_kind_d = pend_kind_q;
    out_v_d     = out_v_q;
    out_last_d  = out_last_q;
    out_sym_d   = out_sym_q;
    out_kind_d  = out_kind_q;
    if (push) begin
      out_v_d    = 1'b1;
      out_last_d = pend_last_q || fin;
      out_sym_d  = pend_sym_q;
      out_kind_d = pend_kind_q;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
    if (gen) begin
      pend_v_d    = 1'b1;
      pend_last_d = gen_last;
      pend_sym_d  = gen_sym;
      pend_kind_d = gen_kind;
    end else if (push) begin
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      fill_q   <= '0;
      mode_q   <= MODE_IDLE;
      pad_q    <= 3'd0;
      last_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      win_q    <= win_d;
      fill_q   <= fill_d;
      mode_q   <= mode_d;
      pad_q    <= pad_d;
      last_q   <= last_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_last_q <= pend_last_d;
    pend_sym_q  <= pend_sym_d;
    pend_kind_q <= pend_kind_d;
    out_last_q  <= out_last_d;
    out_sym_q   <= out_sym_d;
    out_kind_q  <= out_kind_d;
  end

  assign out_valid_o = out_v_q;
  assign out_sym_o   = out_sym_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

endmodule

### rtl/static_huffman_packet_decoder.sv
// Top level of the static prefix-code packet decoder.
// Input stream: one packet byte per word; tuser marks the header byte that starts a
// packet, tlast marks its final byte. Header 255 passes the packet through raw,
// header 0..7 gives the pad-bit count of a coded packet, anything else is an error.
// Output stream: tdata carries the symbol, tuser the kind (symbol, clean end, error),
// tlast marks the final word caused by one input byte.
// An input word is taken while the sequencer is idle and the pending slot has room;
// a coded byte then runs one table lookup per decoded symbol plus one that ends the
// byte, each also only when the pending slot has room. The lookup of the 10-bit
// window against the fixed code table forms this lookup loop.
// A result word reaches the output register by way of a pending slot: it waits there
// until the decoder knows whether it is the last one.
// Reset clears the window, leaves the block idle awaiting a header and empties both
// the pending slot and the output register. When the receiver stalls, the pending
// slot fills and the decoder holds its state and stops taking input until the
// output word is taken.
module static_huffman_packet_decoder #(
  parameter int unsigned MAX_CODE_BITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte
  input  logic       s_axis_tuser,   // first_of_packet
  input  logic       s_axis_tlast,   // last_of_packet
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // symbol
  output logic [1:0] m_axis_tuser,   // kind
  output logic       m_axis_tlast    // last_of_run
);
  import shpd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  shpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  shpd_datapath #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_byte_i   (s_axis_tdata),
    .in_first_i  (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sym_o   (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.dec_step, cmd.raw_end}))
    else $error("more than one datapath command in a cycle");

  a_step_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.dec_step || cmd.raw_end) |-> stat.can_act)
    else $error("datapath step issued without room for its word");

  a_nonsym_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != KIND_SYM)) |-> (m_axis_tdata == 8'd0))
    else $error("end or error word carries a nonzero symbol");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != KIND_SYM)) |-> m_axis_tlast)
    else $error("end or error word not marked last");

endmodule

### tb/static_huffman_packet_decoder_tb.sv
// Self-checking testbench for the static prefix-code packet decoder.
module static_huffman_packet_decoder_tb;
  import shpd_pkg::*;

  typedef struct packed {
    logic [7:0] sym;
    logic [1:0] kind;
    logic       lst;
  } word_t;

  typedef enum logic [1:0] {
    PM_IDLE, PM_RAW, PM_CODED, PM_DISCARD
  } pmode_e;

  // Code table: bit 0 of each code holds the first received bit.
  class decode_scoreboard;
    word_t       pending_q[$];
    word_t       run_q[$];
    int          errors;
    logic [31:0] win;
    int          fill;
    pmode_e      mode;
    int          pad;
    logic [9:0]  cbits [NUM_CODES];
    int          clen  [NUM_CODES];
    logic [7:0]  csym  [NUM_CODES];

    function void init();
      errors = 0;
      win = 0;
      fill = 0;
      mode = PM_IDLE;
      pad = 0;
    endfunction

    function void load_codes();
      logic [21:0] ent;
      for (int e = 0; e < NUM_CODES; e++) begin
        ent = CODE_TAB[e];
        clen[e] = int'(ent[21:18]);
        cbits[e] = '0;
        csym[e] = ent[7:0];
        for (int i = 0; i < clen[e]; i++) cbits[e][i] = ent[8 + clen[e] - 1 - i];
      end
    endfunction

    function bit lookup(output int len, output logic [7:0] sy);
      for (int l = CODE_LEN_MIN; l <= 10 && l <= fill; l++)
        for (int e = 0; e < NUM_CODES; e++)
          if (clen[e] == l && ((win[9:0] ^ cbits[e]) & ((10'd1 << l) - 1)) == 0) begin
            len = l;
            sy = csym[e];
            return 1;
          end
      return 0;
    endfunction

    function void put(logic [7:0] s, logic [1:0] k);
      word_t w;
      w.sym = s;
      w.kind = k;
      w.lst = 1'b0;
      run_q = {run_q, w};
    endfunction

    function void note_input(logic [7:0] b, logic first, logic last);
      int len;
      logic [7:0] sy;
      bit bad;
      word_t w;
      if (first) begin
        win = 0; fill = 0; pad = 0;
        if (b == HDR_RAW) begin
          mode = PM_RAW;
          if (last) begin put(8'd0, KIND_END); mode = PM_IDLE; end
        end else if (b <= HDR_PAD_MAX) begin
          pad = b; mode = PM_CODED;
          if (last) begin
            put(8'd0, (pad == 0) ? KIND_END : KIND_ERR);
            mode = PM_IDLE;
          end
        end else begin
          put(8'd0, KIND_ERR);
          mode = last ? PM_IDLE : PM_DISCARD;
        end
      end else if (mode == PM_DISCARD) begin
        if (last) mode = PM_IDLE;
      end else if (mode == PM_RAW) begin
        put(b, KIND_SYM);
        if (last) begin put(8'd0, KIND_END); mode = PM_IDLE; end
      end else if (mode == PM_CODED) begin
        win = win | (32'(b) << fill);
        fill += 8;
        if (!last) begin
          while (fill >= 3) begin
            if (lookup(len, sy)) begin
              put(sy, KIND_SYM);
              win >>= len; fill -= len;
            end else begin
              if (fill >= 10) begin
                put(8'd0, KIND_ERR);
                mode = PM_DISCARD;
              end
              break;
            end
          end
        end else begin
          bad = 0;
          while (fill > pad) begin
            if (!lookup(len, sy)) begin bad = 1; break; end
            put(sy, KIND_SYM);
            win >>= len; fill -= len;
          end
          put(8'd0, bad ? KIND_ERR : KIND_END);
          mode = PM_IDLE; win = 0; fill = 0;
        end
      end
      if (run_q.size() > 0) begin
        w = run_q[run_q.size()-1];
        w.lst = 1'b1;
        run_q[run_q.size()-1] = w;
      end
      pending_q = {pending_q, run_q};
      run_q.delete();
    endfunction

    function void check_word(logic [7:0] sy, logic [1:0] k, logic l);
      word_t w;
      if (pending_q.size() == 0) begin
        $error("unexpected word: symbol %0d kind %0d last %0d", sy, k, l);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      if (w.kind != k) begin
        $error("kind: expected %0d actual %0d", w.kind, k); errors++;
      end
      if (w.sym != sy) begin
        $error("symbol: expected %0d actual %0d", w.sym, sy); errors++;
      end
      if (w.lst != l) begin
        $error("last_of_run: expected %0d actual %0d", w.lst, l); errors++;
      end
    endfunction
  endclass

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       s_axis_tvalid = 0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 0;  // data_byte
  logic       s_axis_tuser = 0;  // first_of_packet
  logic       s_axis_tlast = 0;  // last_of_packet
  logic       m_axis_tvalid;
  logic       m_axis_tready = 0;
  logic [7:0] m_axis_tdata;      // symbol
  logic [1:0] m_axis_tuser;      // kind
  logic       m_axis_tlast;      // last_of_run

  decode_scoreboard sb;
  bit quiet;   // no idling on either side while set
  int sent;

  static_huffman_packet_decoder u_dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: random stalls, checks each accepted word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      m_axis_tready <= quiet || ($urandom_range(99) >= 30);
    end
  end

  task automatic send_word(logic [7:0] b, logic first, logic last);
    while (!quiet && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= first;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(b, first, last);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_raw(int nb);
    send_word(HDR_RAW, 1'b1, nb == 0);
    for (int i = 0; i < nb; i++) send_word(8'($urandom()), 1'b0, i == nb - 1);
  endtask

  // Coded packet built from random symbols, so most of it decodes cleanly.
  task automatic send_coded(int nsym, int pad_sel);
    logic [7:0] bytes[$];
    logic [63:0] acc;
    int nb, e, padn, total;
    logic [7:0] hdr;
    acc = 0; nb = 0;
    for (int i = 0; i < nsym; i++) begin
      e = $urandom_range(NUM_CODES - 1);
      for (int j = 0; j < sb.clen[e]; j++) begin
        acc[nb] = sb.cbits[e][j];
        nb++;
        if (nb == 8) begin bytes = {bytes, acc[7:0]}; acc = 0; nb = 0; end
      end
    end
    if (nb > 0) begin
      acc[7:0] = acc[7:0] | (8'($urandom()) << nb);
      bytes = {bytes, acc[7:0]};
      padn = 8 - nb;
    end else padn = 0;
    hdr = (pad_sel < 0) ? 8'(padn) : 8'(pad_sel);
    if (bytes.size() > 0 && $urandom_range(9) == 0)
      bytes[$urandom_range(bytes.size() - 1)] = 8'($urandom());
    total = bytes.size();
    send_word(hdr, 1'b1, total == 0);
    foreach (bytes[i]) send_word(bytes[i], 1'b0, i == total - 1);
  endtask

  initial begin
    int sel, n;
    bit drained;
    sb = new();
    sb.init();
    sb.load_codes();
    quiet = 0;
    sent = 0;
    drained = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (sent < 470) begin
      quiet = (sent >= 200) && (sent < 280);
      sel = $urandom_range(99);
      n = $urandom_range(8);
      if (sel < 50) begin
        send_coded(1 + $urandom_range(11), -1);
      end else if (sel < 60) begin
        send_coded(1 + n, $urandom_range(7));
      end else if (sel < 75) begin
        send_raw(n);
      end else if (sel < 82) begin
        send_word(8'(8 + $urandom_range(246)), 1'b1, n == 0);
        for (int i = 0; i < n; i++) send_word(8'($urandom()), 1'b0, i == n - 1);
      end else if (sel < 88) begin
        send_word(8'($urandom_range(7)), 1'b1, 1'b1);
      end else if (sel < 93) begin
        send_word(8'($urandom()), 1'b0, 1'($urandom_range(1)));
      end else begin
        // Packet cut short by the header of the next one.
        send_word(8'($urandom_range(7)), 1'b1, 1'b0);
        for (int i = 0; i < n; i++) send_word(8'($urandom()), 1'b0, 1'b0);
      end
      if (!drained && sent >= 320) begin
        drain();
        drained = 1;
      end
    end
    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
